[rtl/core/mpte_pkg.sv]
`default_nettype none

package mpte_pkg;

  localparam int MPTE_MARKER_LEN = 48;
  localparam int MPTE_ENTITY_MAX = 10;
  localparam int MPTE_ROM_DEPTH  = 64;
  localparam int MPTE_POS_W      = 6;
  localparam int MPTE_ELEN_W     = 4;
  localparam int MPTE_ENT_SLOTS  = 4;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_QUOT = 8'h22;

  typedef logic [7:0] byte_arr64_t [MPTE_ROM_DEPTH];
  typedef logic [7:0] byte_arr4_t  [4];

  // Start marker as byte codes; positions past the marker text hold zero.
  localparam byte_arr64_t MARKER_ROM = '{
    8'h3C, 8'h70, 8'h20, 8'h63, 8'h6C, 8'h61, 8'h73, 8'h73,
    8'h3D, 8'h22, 8'h50, 8'h72, 8'h6F, 8'h66, 8'h69, 8'h6C,
    8'h65, 8'h54, 8'h77, 8'h65, 8'h65, 8'h74, 8'h2D, 8'h74,
    8'h65, 8'h78, 8'h74, 8'h20, 8'h6A, 8'h73, 8'h2D, 8'h74,
    8'h77, 8'h65, 8'h65, 8'h74, 8'h2D, 8'h74, 8'h65, 8'h78,
    8'h74, 8'h20, 8'h75, 8'h2D, 8'h64, 8'h69, 8'h72, 8'h22,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam byte_arr4_t CLOSE_ROM = '{8'h3C, 8'h2F, 8'h70, 8'h3E};

  typedef enum logic [4:0] {
    MODE_SEARCH = 5'b00001,
    MODE_SKIP   = 5'b00010,
    MODE_TEXT   = 5'b00100,
    MODE_ENTITY = 5'b01000,
    MODE_CLOSE  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic clear;
    logic push;
  } ent_ctl_t;

  typedef struct packed {
    logic                   hit;
    logic [7:0]             code;
    logic [MPTE_ELEN_W-1:0] len;
  } ent_stat_t;

endpackage

`default_nettype wire

[rtl/core/mpte_entity.sv]
`default_nettype none

module mpte_entity
  import mpte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ent_ctl_t  ctl,
  input  wire logic [7:0] data,
  output      ent_stat_t stat
);

  logic [7:0]             chars_r [MPTE_ENT_SLOTS];
  logic [MPTE_ELEN_W-1:0] len_r;
  logic [MPTE_ELEN_W-1:0] len_nxt;

  always_comb begin
    len_nxt = len_r;
    if (ctl.clear) begin
      len_nxt = '0;
    end else if (ctl.push) begin
      len_nxt = len_r + MPTE_ELEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear && (len_r < MPTE_ELEN_W'(MPTE_ENT_SLOTS))) begin
      chars_r[len_r[1:0]] <= data;
    end
  end

  always_comb begin
    stat.len  = len_r;
    stat.hit  = 1'b0;
    stat.code = CH_APOS;
    if (len_r == MPTE_ELEN_W'(3) && chars_r[0] == 8'h23 && chars_r[1] == 8'h33 &&
        chars_r[2] == 8'h39) begin
      stat.hit  = 1'b1;
      stat.code = CH_APOS;
    end else if (len_r == MPTE_ELEN_W'(4) && chars_r[0] == 8'h71 &&
                 chars_r[1] == 8'h75 && chars_r[2] == 8'h6F && chars_r[3] == 8'h74) begin
      stat.hit  = 1'b1;
      stat.code = CH_QUOT;
    end
  end

endmodule

`default_nettype wire

[rtl/core/marked_paragraph_text_extractor.sv]
`default_nettype none

// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | in_byte[7:0]
// out     | output    | out_valid / out_stall | out_byte[7:0]
//
// One byte is taken per cycle unless stalled; any result is then registered.
// The rate is set by the single state update and result register per byte.
// Reset is synchronous on rst_n low and returns the block to marker search.
// A stalled result holds in the result register and stalls the input only
// while it is still waiting.

module marked_paragraph_text_extractor
  import mpte_pkg::*;
#(
  parameter int MARKER_LEN = MPTE_MARKER_LEN,
  parameter int ENTITY_MAX = MPTE_ENTITY_MAX
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_byte,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_byte
);

  mode_t                 mode_r, mode_nxt;
  logic [MPTE_POS_W-1:0] marker_pos_r, marker_pos_nxt;
  logic [1:0]            close_pos_r, close_pos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic                  in_acc;
  logic                  emit;
  logic [7:0]            emit_byte;
  logic [MPTE_POS_W:0]   pos_inc;
  ent_ctl_t              ent_ctl;
  ent_stat_t             ent_stat;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign pos_inc   = {1'b0, marker_pos_r} + (MPTE_POS_W+1)'(1);

  mpte_entity u_entity (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ent_ctl),
    .data  (in_byte),
    .stat  (ent_stat)
  );

  always_comb begin
    mode_nxt       = mode_r;
    marker_pos_nxt = marker_pos_r;
    close_pos_nxt  = close_pos_r;
    emit           = 1'b0;
    emit_byte      = in_byte;
    ent_ctl        = '0;
    case (mode_r)
      MODE_SKIP: begin
        if (in_byte == CH_GT) begin
          mode_nxt = MODE_TEXT;
        end
      end
      MODE_TEXT: begin
        if (in_byte == CH_LT) begin
          mode_nxt      = MODE_CLOSE;
          close_pos_nxt = 2'd1;
        end else if (in_byte == CH_AMP) begin
          mode_nxt      = MODE_ENTITY;
          ent_ctl.clear = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      MODE_ENTITY: begin
        if (in_byte == CH_SEMI) begin
          emit          = ent_stat.hit;
          emit_byte     = ent_stat.code;
          mode_nxt      = MODE_TEXT;
          ent_ctl.clear = 1'b1;
        end else if (ent_stat.len >= MPTE_ELEN_W'(ENTITY_MAX)) begin
          mode_nxt      = MODE_TEXT;
          ent_ctl.clear = 1'b1;
        end else begin
          ent_ctl.push = 1'b1;
        end
      end
      MODE_CLOSE: begin
        if (in_byte == CLOSE_ROM[close_pos_r]) begin
          if (close_pos_r == 2'd3) begin
            emit           = 1'b1;
            emit_byte      = CH_NL;
            mode_nxt       = MODE_SEARCH;
            marker_pos_nxt = '0;
            close_pos_nxt  = 2'd0;
          end else begin
            close_pos_nxt = close_pos_r + 2'd1;
          end
        end else begin
          mode_nxt      = (in_byte == CH_GT) ? MODE_TEXT : MODE_SKIP;
          close_pos_nxt = 2'd0;
        end
      end
      default: begin
        mode_nxt = MODE_SEARCH;
        if (in_byte == MARKER_ROM[marker_pos_r]) begin
          if (pos_inc >= (MPTE_POS_W+1)'(MARKER_LEN)) begin
            mode_nxt       = MODE_SKIP;
            marker_pos_nxt = '0;
          end else begin
            marker_pos_nxt = pos_inc[MPTE_POS_W-1:0];
          end
        end else begin
          marker_pos_nxt = (in_byte == MARKER_ROM[0]) ? MPTE_POS_W'(1) : '0;
        end
      end
    endcase
    if (!in_acc) begin
      ent_ctl = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_SEARCH;
      marker_pos_r <= '0;
      close_pos_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r       <= mode_nxt;
        marker_pos_r <= marker_pos_nxt;
        close_pos_r  <= close_pos_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

`ifndef SYNTHESIS
  a_close_newline: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && mode_r == MODE_CLOSE && close_pos_r == 2'd3 && in_byte == CH_GT
    |=> out_valid_r && out_byte_r == CH_NL && mode_r == MODE_SEARCH)
    else $error("closing tag did not emit a newline");

  a_lt_enters_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && mode_r == MODE_TEXT && in_byte == CH_LT
    |=> mode_r == MODE_CLOSE && close_pos_r == 2'd1 && !out_valid_r)
    else $error("tag start in text was not handled");

  a_entity_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_ENTITY |-> ent_stat.len <= MPTE_ELEN_W'(ENTITY_MAX))
    else $error("entity length beyond limit");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc))
    else $error("result appeared without an accepted item");
`endif

endmodule

`default_nettype wire
